// ===== src/pcmdac_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pcmdac_pkg;

    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;

    localparam logic PORT_DATA    = 1'b0;
    localparam logic PORT_CONTROL = 1'b1;

    localparam int CTRL_W = 5;

    localparam int CTRL_EDGE_BIT = 0;
    localparam int CTRL_DAC_BIT  = 1;
    localparam int CTRL_ADC_BIT  = 2;
    localparam int CTRL_HOLD_BIT = 4;

    localparam logic [7:0] SAMPLE_MID = 8'h80;

    typedef struct packed {
        logic [1:0]         mode;
        logic               port_select;
        logic [7:0]         write_data;
        logic signed [15:0] audio_in;
    } req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       dac_write;
        logic [7:0] dac_value;
        logic       mute_all;
    } rsp_t;

endpackage

`default_nettype wire

// ===== src/pcm_dac_adc_comparator_port_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel | direction | handshake              | payload
// req     | in        | req_valid / req_ready  | pcmdac_pkg::req_t
// rsp     | out       | rsp_valid / rsp_ready  | pcmdac_pkg::rsp_t
//
// one item per cycle while the result register is not stalled; each item gives one result,
// passing first through the input register and then the result register
// the register updates happen as an item moves from the input register to
// the result register; a stalled result holds both stages, and an empty input
// register still takes one more item while the result register waits
// reset (rst_n low) empties both stages and loads the port registers

module pcm_dac_adc_comparator_port_unit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire pcmdac_pkg::req_t  req,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output pcmdac_pkg::rsp_t       rsp
);

    logic                          in_valid_reg;
    pcmdac_pkg::req_t              in_item_reg;
    logic                          out_valid_reg;
    pcmdac_pkg::rsp_t              out_item_reg;

    logic [1:0]                    tick_count_reg, tick_count_next;
    logic [pcmdac_pkg::CTRL_W-1:0] control_reg, control_next;
    logic [7:0]                    data_value_reg, data_value_next;
    logic [7:0]                    held_sample_reg, held_sample_next;
    logic                          mute_reg, mute_next;

    logic                          advance;
    logic [7:0]                    quot;
    logic [7:0]                    live_sample;
    logic [7:0]                    cmp_sample;
    logic                          cmp_ge;
    logic [pcmdac_pkg::CTRL_W-1:0] new_ctrl;
    logic [pcmdac_pkg::CTRL_W-1:0] change;
    pcmdac_pkg::rsp_t              result;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp_ready);
    assign req_ready = !in_valid_reg || advance;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_item_reg;

    // truncating divide by 256, then offset to unsigned; the midpoint while the adc bit is off
    always_comb
    begin
        quot = in_item_reg.audio_in[15:8];
        if (in_item_reg.audio_in[15] && (in_item_reg.audio_in[7:0] != 8'd0))
        begin
            quot = in_item_reg.audio_in[15:8] + 8'd1;
        end
        if (control_reg[pcmdac_pkg::CTRL_ADC_BIT])
        begin
            live_sample = quot + pcmdac_pkg::SAMPLE_MID;
        end
        else
        begin
            live_sample = pcmdac_pkg::SAMPLE_MID;
        end
        cmp_sample = control_reg[pcmdac_pkg::CTRL_HOLD_BIT] ? held_sample_reg : live_sample;
        cmp_ge     = cmp_sample >= data_value_reg;
    end

    always_comb
    begin
        tick_count_next  = tick_count_reg;
        control_next     = control_reg;
        data_value_next  = data_value_reg;
        held_sample_next = held_sample_reg;
        mute_next        = mute_reg;
        result           = '0;
        new_ctrl         = in_item_reg.write_data[pcmdac_pkg::CTRL_W-1:0];
        change           = control_reg ^ new_ctrl;

        case (in_item_reg.mode)
            pcmdac_pkg::MODE_TICK:
            begin
                tick_count_next = tick_count_reg + 2'd1;
            end
            pcmdac_pkg::MODE_READ:
            begin
                if (in_item_reg.port_select == pcmdac_pkg::PORT_DATA)
                begin
                    result.read_data = {6'd0, tick_count_reg};
                end
                else
                begin
                    result.read_data = {cmp_ge, 2'd0, control_reg};
                end
            end
            pcmdac_pkg::MODE_WRITE:
            begin
                if (in_item_reg.port_select == pcmdac_pkg::PORT_DATA)
                begin
                    tick_count_next = 2'd0;
                    data_value_next = in_item_reg.write_data;
                    if (control_reg[pcmdac_pkg::CTRL_DAC_BIT])
                    begin
                        result.dac_write = 1'b1;
                        result.dac_value = in_item_reg.write_data;
                    end
                end
                else
                begin
                    control_next = new_ctrl;
                    if (change[pcmdac_pkg::CTRL_EDGE_BIT] && !new_ctrl[pcmdac_pkg::CTRL_EDGE_BIT])
                    begin
                        result.dac_write = 1'b1;
                        result.dac_value = data_value_reg;
                    end
                    // hold latches with the adc enable as newly written
                    if (change[pcmdac_pkg::CTRL_HOLD_BIT] && new_ctrl[pcmdac_pkg::CTRL_HOLD_BIT])
                    begin
                        held_sample_next = new_ctrl[pcmdac_pkg::CTRL_ADC_BIT]
                                         ? quot + pcmdac_pkg::SAMPLE_MID
                                         : pcmdac_pkg::SAMPLE_MID;
                    end
                    mute_next = !new_ctrl[pcmdac_pkg::CTRL_DAC_BIT];
                end
            end
            default:
            begin
            end
        endcase
        result.mute_all = mute_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            tick_count_reg  <= 2'd0;
            control_reg     <= '0;
            data_value_reg  <= pcmdac_pkg::SAMPLE_MID;
            held_sample_reg <= pcmdac_pkg::SAMPLE_MID;
            mute_reg        <= 1'b0;
        end
        else
        begin
            if (req_ready)
            begin
                in_valid_reg <= req_valid;
            end
            if (advance)
            begin
                out_valid_reg   <= 1'b1;
                tick_count_reg  <= tick_count_next;
                control_reg     <= control_next;
                data_value_reg  <= data_value_next;
                held_sample_reg <= held_sample_next;
                mute_reg        <= mute_next;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
        begin
            in_item_reg <= req;
        end
        if (advance)
        begin
            out_item_reg <= result;
        end
    end

endmodule

`default_nettype wire
